// File: sv/pkfc_pkg.sv
// pkfc_pkg: shared types and constants for the pair-keyed fifo cache
// request/result payload structs, opcodes and the controller/datapath interface
// no dependencies
package pkfc_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned OCC_W  = 8;
  localparam int unsigned OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] outer_key;
    logic [DATA_W-1:0] inner_key;
    logic [DATA_W-1:0] new_handle;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] found_handle;
    logic              evicted;
    logic [DATA_W-1:0] evicted_handle;
    logic [OCC_W-1:0]  occupancy;
  } res_t;

  // how the finishing request forms its result
  typedef enum logic [2:0] {
    FIN_MISS,
    FIN_HIT,
    FIN_INS,
    FIN_EVICT,
    FIN_CLEAR,
    FIN_NOP
  } fin_kind_t;

  typedef struct packed {
    logic      load;
    logic      scan_init;
    logic      scan_run;
    logic      rd_en;
    logic      wr_tail;
    logic      wr_head;
    logic      clear;
    logic      finish;
    fin_kind_t kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            full;
    logic            match;
    logic            scan_done;
  } ctl_sts_t;

endpackage

// File: sv/pair_keyed_fifo_cache.sv
// pair_keyed_fifo_cache: fully associative key-pair cache, fifo replacement.
// after acceptance the request is decoded; insert, clear and unused opcodes finish
//   there, an insert into a full table adds an eviction read and write, and a
//   lookup scans the valid entries oldest first: the scan reads one ram entry per cycle.
// throughput: one request at a time, busy until the result is registered.
// reset: synchronous active-low rst_n empties the table; ram contents are not cleared.
module pair_keyed_fifo_cache #(
  parameter int unsigned CAPACITY     = 128,
  parameter int unsigned KEY_WIDTH    = 64,
  parameter int unsigned HANDLE_WIDTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pkfc_pkg::req_t in_req,
  output logic           out_valid,
  output pkfc_pkg::res_t out_res
);
  import pkfc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  pkfc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pkfc_dp #(
    .CAPACITY     (CAPACITY),
    .KEY_WIDTH    (KEY_WIDTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// File: sv/pkfc_ram.sv
// pkfc_ram: generic single-write, single-read ram with registered read data
// read data holds when no read is issued
// no dependencies
module pkfc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/pkfc_dp.sv
// pkfc_dp: datapath of the pair-keyed fifo cache
// entry ram, ring head and count, scan counters, request and result registers
// depends on pkfc_pkg and pkfc_ram
module pkfc_dp #(
  parameter int unsigned CAPACITY     = 128,
  parameter int unsigned KEY_WIDTH    = 64,
  parameter int unsigned HANDLE_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pkfc_pkg::req_t    in_req,
  input  pkfc_pkg::ctl_cmd_t cmd,
  output pkfc_pkg::ctl_sts_t sts,
  output logic              out_valid,
  output pkfc_pkg::res_t    out_res
);
  import pkfc_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = 2 * KEY_WIDTH + HANDLE_WIDTH;

  req_t              req_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     rd_slot_r, rd_slot_nxt;
  logic [CW-1:0]     off_r, off_nxt;
  logic              pend_r, pend_nxt;
  logic              res_vld_r;
  res_t              res_r, res_nxt;

  logic              issue;
  logic [CW:0]       tail_sum;
  logic [AW-1:0]     tail_slot;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;
  logic [KEY_WIDTH-1:0]    rd_outer, rd_inner;
  logic [HANDLE_WIDTH-1:0] rd_handle;

  assign rd_outer  = ram_rdata[EW-1 -: KEY_WIDTH];
  assign rd_inner  = ram_rdata[HANDLE_WIDTH +: KEY_WIDTH];
  assign rd_handle = ram_rdata[HANDLE_WIDTH-1:0];

  // ring slot after the newest entry, one compare-subtract wrap
  always_comb begin
    tail_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (tail_sum >= (CW+1)'(CAPACITY)) begin
      tail_sum = tail_sum - (CW+1)'(CAPACITY);
    end
    tail_slot = tail_sum[AW-1:0];
  end

  assign issue = cmd.scan_run && (off_r < count_r);

  assign ram_we    = cmd.wr_tail || cmd.wr_head;
  assign ram_waddr = cmd.wr_head ? head_r : tail_slot;
  assign ram_wdata = {req_r.outer_key[KEY_WIDTH-1:0], req_r.inner_key[KEY_WIDTH-1:0],
                      req_r.new_handle[HANDLE_WIDTH-1:0]};
  assign ram_re    = cmd.rd_en || issue;

  pkfc_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_slot_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (cmd.wr_head) begin
        head_nxt = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);
      end
      if (cmd.wr_tail) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_comb begin
    rd_slot_nxt = rd_slot_r;
    off_nxt     = off_r;
    pend_nxt    = pend_r;
    if (cmd.scan_init) begin
      rd_slot_nxt = head_r;
      off_nxt     = '0;
      pend_nxt    = 1'b0;
    end else if (cmd.scan_run) begin
      pend_nxt = issue;
      if (issue) begin
        off_nxt     = off_r + CW'(1);
        rd_slot_nxt = (rd_slot_r == AW'(CAPACITY - 1)) ? '0 : rd_slot_r + AW'(1);
      end
    end
  end

  always_comb begin
    res_nxt                = '0;
    res_nxt.hit            = (cmd.kind == FIN_HIT);
    res_nxt.evicted        = (cmd.kind == FIN_EVICT);
    res_nxt.found_handle   = (cmd.kind == FIN_HIT) ? DATA_W'(rd_handle) : '0;
    res_nxt.evicted_handle = (cmd.kind == FIN_EVICT) ? DATA_W'(rd_handle) : '0;
    res_nxt.occupancy      = OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      pend_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      pend_r    <= pend_nxt;
      res_vld_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.finish) begin
      res_r <= res_nxt;
    end
    rd_slot_r <= rd_slot_nxt;
    off_r     <= off_nxt;
  end

  assign sts.opcode    = req_r.opcode;
  assign sts.full      = (count_r == CW'(CAPACITY));
  assign sts.match     = pend_r && (rd_outer == req_r.outer_key[KEY_WIDTH-1:0])
                         && (rd_inner == req_r.inner_key[KEY_WIDTH-1:0]);
  assign sts.scan_done = !(off_r < count_r);

  assign out_valid = res_vld_r;
  assign out_res   = res_r;

endmodule

// File: sv/pkfc_ctrl.sv
// pkfc_ctrl: controller state machine of the pair-keyed fifo cache
// sequences decode, scan, eviction read/write and result strobe
// depends on pkfc_pkg
module pkfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pkfc_pkg::ctl_sts_t sts,
  output pkfc_pkg::ctl_cmd_t cmd
);
  import pkfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_EVICT_RD,
    S_EVICT_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = FIN_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.opcode)
          OP_LOOKUP: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          OP_INSERT: begin
            if (sts.full) begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_EVICT_RD;
            end else begin
              cmd.wr_tail = 1'b1;
              cmd.finish  = 1'b1;
              cmd.kind    = FIN_INS;
              state_nxt   = S_IDLE;
            end
          end
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.finish = 1'b1;
            cmd.kind   = FIN_CLEAR;
            state_nxt  = S_IDLE;
          end
          default: begin
            cmd.finish = 1'b1;
            cmd.kind   = FIN_NOP;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        // a match on the entry read last cycle wins over running out of entries
        if (sts.match) begin
          cmd.finish = 1'b1;
          cmd.kind   = FIN_HIT;
          state_nxt  = S_IDLE;
        end else if (sts.scan_done) begin
          cmd.finish = 1'b1;
          cmd.kind   = FIN_MISS;
          state_nxt  = S_IDLE;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_EVICT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EVICT_WR;
      end
      S_EVICT_WR: begin
        cmd.wr_head = 1'b1;
        cmd.finish  = 1'b1;
        cmd.kind    = FIN_EVICT;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: sv/pkfc_checker.sv
// pkfc_port_checks: port-level assertions for pair_keyed_fifo_cache
// bound to the top level below
// depends on pkfc_pkg
module pkfc_port_checks #(
  parameter int unsigned CAPACITY = 128
) (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input pkfc_pkg::res_t out_res
);
  import pkfc_pkg::*;

  // an accepted request keeps the block busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // no two result strobes back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.hit) |-> (!out_res.evicted && out_res.evicted_handle == '0))
    else $error("lookup hit reported an eviction");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.hit) |-> (out_res.found_handle == '0))
    else $error("nonzero handle without a hit");

  // eviction only happens from a full table, which stays full
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.evicted) |-> (out_res.occupancy == OCC_W'(CAPACITY)))
    else $error("eviction from a table that is not full");

endmodule

bind pair_keyed_fifo_cache pkfc_port_checks #(
  .CAPACITY (CAPACITY)
) u_pkfc_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

// File: dv/pkfc_checker.sv
// pkfc_checker: watches the request and result channels of pair_keyed_fifo_cache,
// predicts each result from its own copy of the table and compares them in order
// depends on pkfc_pkg
module pkfc_checker #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  pkfc_pkg::req_t in_req,
  input  logic           out_valid,
  input  pkfc_pkg::res_t out_res,
  output int             mismatch_count,
  output int             replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import pkfc_pkg::*;

  logic [DATA_W-1:0] outer_tbl  [CAPACITY];
  logic [DATA_W-1:0] inner_tbl  [CAPACITY];
  logic [DATA_W-1:0] handle_tbl [CAPACITY];
  int unsigned       head_slot;
  int unsigned       live_entries;
  res_t              replies_due [$];
  res_t              reply_want;

  function automatic res_t cache_apply(req_t r);
    res_t        res;
    int unsigned s;
    res = '0;
    case (r.opcode)
      OP_LOOKUP: begin
        // oldest to newest, first match wins
        for (int unsigned i = 0; i < live_entries; i++) begin
          s = (head_slot + i) % CAPACITY;
          if (outer_tbl[s] == r.outer_key && inner_tbl[s] == r.inner_key) begin
            res.hit          = 1'b1;
            res.found_handle = handle_tbl[s];
            break;
          end
        end
      end
      OP_INSERT: begin
        if (live_entries >= CAPACITY) begin
          // full table: the oldest entry gives up its slot and the head moves on
          s                  = head_slot;
          res.evicted        = 1'b1;
          res.evicted_handle = handle_tbl[s];
          head_slot          = (head_slot + 1) % CAPACITY;
        end else begin
          s = (head_slot + live_entries) % CAPACITY;
          live_entries++;
        end
        outer_tbl[s]  = r.outer_key;
        inner_tbl[s]  = r.inner_key;
        handle_tbl[s] = r.new_handle;
      end
      OP_CLEAR: begin
        live_entries = 0;
        head_slot    = 0;
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(live_entries);
    return res;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_slot      = 0;
      live_entries   = 0;
      mismatch_count = 0;
      replies_due.delete();
    end else begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no request outstanding: %h", $time, out_res);
        end else begin
          reply_want = replies_due.pop_front();
          check_field("hit", DATA_W'(reply_want.hit), DATA_W'(out_res.hit));
          check_field("found_handle",   reply_want.found_handle,   out_res.found_handle);
          check_field("evicted", DATA_W'(reply_want.evicted), DATA_W'(out_res.evicted));
          check_field("evicted_handle", reply_want.evicted_handle, out_res.evicted_handle);
          check_field("occupancy", DATA_W'(reply_want.occupancy),
                      DATA_W'(out_res.occupancy));
        end
      end
      if (start && !busy)
        replies_due.push_back(cache_apply(in_req));
    end
    replies_owed <= replies_due.size();
  end

endmodule

// File: dv/tb_top.sv
// tb_top: drives lookup, insert, clear and unused-opcode requests into pair_keyed_fifo_cache
// and gives the verdict; prediction and comparison live in pkfc_checker
// depends on pkfc_pkg, pkfc_checker and the cache rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pkfc_pkg::*;

  localparam int unsigned     CAPACITY     = 128;
  localparam int unsigned     N_ITEMS      = 1850;
  localparam int unsigned     CALM_TAIL    = 150;
  localparam int unsigned     DRAIN_CYCLES = CAPACITY + 16;
  localparam int unsigned     CYCLE_LIMIT  = 1_200_000;
  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam logic [DATA_W-1:0] KEY_A = 64'hA5A5_0F0F_3C3C_9669;
  localparam logic [DATA_W-1:0] KEY_B = 64'h5A5A_F0F0_C3C3_6996;

  typedef struct packed {
    logic [DATA_W-1:0] outer;
    logic [DATA_W-1:0] inner;
  } key_pair_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  req_t        in_req = '0;
  logic        busy;
  logic        out_valid;
  res_t        out_res;
  int          mismatch_count;
  int          replies_owed;
  int unsigned cycle_count = 0;
  int unsigned n_sent = 0;
  key_pair_t   key_history [$];

  always #5 clk = ~clk;

  pair_keyed_fifo_cache #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  pkfc_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_res        (out_res),
    .mismatch_count (mismatch_count),
    .replies_owed   (replies_owed)
  );

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t pack_request(input logic [OP_W-1:0] op,
                                        input logic [DATA_W-1:0] ko,
                                        input logic [DATA_W-1:0] ki,
                                        input logic [DATA_W-1:0] h);
    req_t r;
    r.opcode     = op;
    r.outer_key  = ko;
    r.inner_key  = ki;
    r.new_handle = h;
    return r;
  endfunction

  // holds start until the request is taken, then maybe idles for a burst
  task automatic send_request(input req_t r);
    in_req <= r;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    if (n_sent + CALM_TAIL < N_ITEMS && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic store_pair(input key_pair_t k, input logic [DATA_W-1:0] h);
    send_request(pack_request(OP_INSERT, k.outer, k.inner, h));
    key_history.push_back(k);
    if (key_history.size() > 2 * CAPACITY)
      void'(key_history.pop_front());
  endtask

  task automatic lookup_pair(input key_pair_t k);
    send_request(pack_request(OP_LOOKUP, k.outer, k.inner, rand64()));
  endtask

  function automatic key_pair_t pick_known();
    return key_history[$urandom_range(0, key_history.size() - 1)];
  endfunction

  task automatic random_item(input int unsigned insert_pct);
    key_pair_t   k;
    int unsigned roll;
    int unsigned flavor;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      send_request(pack_request(OP_UNUSED, rand64(), rand64(), rand64()));
    end else if (roll < 3) begin
      send_request(pack_request(OP_CLEAR, rand64(), rand64(), rand64()));
    end else if (roll < 3 + insert_pct) begin
      // a quarter of the inserts repeat a known pair to build duplicates
      if (key_history.size() > 0 && $urandom_range(0, 3) == 0)
        k = pick_known();
      else
        k = {rand64(), rand64()};
      store_pair(k, rand64());
    end else begin
      flavor = $urandom_range(0, 9);
      if (key_history.size() == 0 || flavor >= 8) begin
        k = {rand64(), rand64()};
      end else begin
        k = pick_known();
        // half-matching pairs must miss
        if (flavor == 6)
          k.inner = rand64();
        else if (flavor == 7)
          k.outer = rand64();
      end
      lookup_pair(k);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests sent", cycle_count, n_sent);
      $display("** pair_keyed_fifo_cache: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] ones;
    int unsigned       ep_len;
    int unsigned       ep_pct;
    bit                first_ep;
    ones     = '1;
    first_ep = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, duplicates, partial matches, unused opcodes, clears
    lookup_pair({64'd0, 64'd0});
    send_request(pack_request(OP_UNUSED, ones, ones, ones));
    store_pair({64'd0, 64'd0}, 64'd0);
    store_pair({ones, ones}, ones);
    store_pair({KEY_A, KEY_B}, 64'h0123_4567_89AB_CDEF);
    store_pair({KEY_A, KEY_B}, 64'hFEDC_BA98_7654_3210);
    lookup_pair({KEY_A, KEY_B});
    lookup_pair({64'd0, 64'd0});
    lookup_pair({ones, ones});
    lookup_pair({KEY_A, ~KEY_B});
    lookup_pair({~KEY_A, KEY_B});
    send_request(pack_request(OP_UNUSED, KEY_A, KEY_B, ones));
    send_request(pack_request(OP_CLEAR, ones, ones, ones));
    lookup_pair({KEY_A, KEY_B});
    send_request(pack_request(OP_CLEAR, 64'd0, 64'd0, 64'd0));
    store_pair({KEY_B, KEY_A}, 64'h8000_0000_0000_0001);
    lookup_pair({KEY_B, KEY_A});
    lookup_pair({KEY_A, KEY_B});
    send_request(pack_request(OP_CLEAR, 64'd0, 64'd0, 64'd0));

    // random episodes, each but the last ending in a clear; the first is insert-heavy
    while (n_sent < N_ITEMS) begin
      ep_len   = first_ep ? 350 : $urandom_range(150, 400);
      ep_pct   = first_ep ? 80 : $urandom_range(35, 80);
      first_ep = 1'b0;
      for (int unsigned j = 0; j < ep_len && n_sent < N_ITEMS; j++)
        random_item(ep_pct);
      if (n_sent < N_ITEMS)
        send_request(pack_request(OP_CLEAR, rand64(), rand64(), rand64()));
    end

    start <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** pair_keyed_fifo_cache: PASSED **");
    else
      $display("** pair_keyed_fifo_cache: FAILED **");
    $finish;
  end

endmodule

// File: pair_keyed_fifo_cache.f
sv/pkfc_pkg.sv
sv/pkfc_ram.sv
sv/pkfc_dp.sv
sv/pkfc_ctrl.sv
sv/pair_keyed_fifo_cache.sv
sv/pkfc_checker.sv
dv/pkfc_checker.sv
dv/tb_top.sv
